FILE: hw/rtl/gpsc_pkg.sv
// shared types and constants for the gamepad report stick calibrator
`timescale 1ns / 1ps

package gpsc_pkg;

  // dead zone register
  localparam int unsigned DZ_W = 6;
  localparam logic [DZ_W-1:0] DZ_RESET = 6'd31;

  // stick breakpoints shared by both axes
  localparam logic [7:0] BRK_INNER_LO = 8'd71;
  localparam logic [7:0] BRK_INNER_HI = 8'd185;
  localparam logic [7:0] CENTRE = 8'd128;

  // outer breakpoints per axis
  localparam logic [7:0] X_BRK_FIRST = 8'd26;
  localparam logic [7:0] X_BRK_LAST = 8'd231;
  localparam logic [7:0] Y_BRK_FIRST = 8'd27;
  localparam logic [7:0] Y_BRK_LAST = 8'd229;

  // targets, index 0 belongs to the lowest breakpoint
  localparam logic [5:0][7:0] X_TGT = {8'd208, 8'd168, 8'd128, 8'd128, 8'd88, 8'd48};
  localparam logic [5:0][7:0] Y_TGT = {8'd48, 8'd88, 8'd128, 8'd128, 8'd168, 8'd208};

  // quotient and offset widths; every sloped segment rises or falls by 40
  localparam int unsigned OFF_W = 6;
  localparam int unsigned NUM_W = 12;

  // source bits in the raw button bytes
  localparam int unsigned MB_Z = 6;
  localparam int unsigned MB_R = 5;
  localparam int unsigned MB_L = 4;
  localparam int unsigned MB_A = 2;
  localparam int unsigned MB_B = 1;
  localparam int unsigned SB_START = 1;

  // destination bits in the button word
  localparam int unsigned BW_START = 0;
  localparam int unsigned BW_R = 2;
  localparam int unsigned BW_Z = 3;
  localparam int unsigned BW_A = 8;
  localparam int unsigned BW_B = 9;
  localparam int unsigned BW_L = 12;

  // one axis after segment selection
  typedef struct packed {
    logic [7:0]       base;
    logic             neg;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] den;
  } seg_t;

  // one axis inside the divider
  typedef struct packed {
    logic [7:0]       base;
    logic             neg;
    logic [OFF_W-1:0] den;
    logic [NUM_W-1:0] rem;
    logic [OFF_W-1:0] quo;
  } div_t;

  // fields that ride alongside the axes
  typedef struct packed {
    logic [15:0] button_word;
    logic [7:0]  axis_cx;
    logic [7:0]  axis_cy;
  } side_t;

endpackage

FILE: hw/rtl/gamepad_report_stick_calibrator.sv
// top level of the gamepad report stick calibrator
`timescale 1ns / 1ps

// Remaps one gamepad report per transfer: the button bits are moved to
// their new positions, both main stick axes go through a six-breakpoint
// piecewise-linear map with a central dead zone, C axis X passes through
// and C axis Y is inverted.
// Input channel: in_valid/in_ready with one port per report field.
// Output channel: out_valid/out_ready with one port per result field.
// Config channel: cfg_valid/cfg_ready with dead_zone as write data; it is
// always ready and must only be written while no report is in flight.
// Five register stages: segment select, three divider stages (two quotient
// bits each) and the output register, in that order. One report per cycle
// is taken while the receiver keeps up; the divider is fully pipelined and
// sets that figure.
// A stalled receiver freezes the whole pipeline (in_ready drops) while
// out_valid is high and out_ready low; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and sets dead_zone to 31.
module gamepad_report_stick_calibrator (
  input  logic        clk,
  input  logic        rst,
  // report input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  main_buttons,
  input  logic [7:0]  start_byte,
  input  logic [7:0]  stick_x,
  input  logic [7:0]  stick_y,
  input  logic [7:0]  cstick_x,
  input  logic [7:0]  cstick_y,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] button_word,
  output logic [7:0]  axis_x,
  output logic [7:0]  axis_y,
  output logic [7:0]  axis_cx,
  output logic [7:0]  axis_cy,
  // dead zone write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [gpsc_pkg::DZ_W-1:0] dead_zone
);

  // pick the segment p falls in, first breakpoint above p wins
  function automatic gpsc_pkg::seg_t classify(input logic [7:0] p,
                                              input logic [gpsc_pkg::DZ_W-1:0] dz,
                                              input logic is_y);
    gpsc_pkg::seg_t s;
    logic [5:0][7:0] tgt;
    logic [7:0] b_first;
    logic [7:0] b_last;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] diff;
    logic [7:0] span;
    tgt     = is_y ? gpsc_pkg::Y_TGT : gpsc_pkg::X_TGT;
    b_first = is_y ? gpsc_pkg::Y_BRK_FIRST : gpsc_pkg::X_BRK_FIRST;
    b_last  = is_y ? gpsc_pkg::Y_BRK_LAST : gpsc_pkg::X_BRK_LAST;
    lo      = gpsc_pkg::CENTRE - {2'b00, dz};
    hi      = gpsc_pkg::CENTRE + {2'b00, dz};
    s.neg   = is_y;
    diff    = 8'd0;
    span    = 8'd1;
    if (p < b_first) begin
      s.base = tgt[0];
    end else if (p < gpsc_pkg::BRK_INNER_LO) begin
      s.base = tgt[0];
      diff   = p - b_first;
      span   = gpsc_pkg::BRK_INNER_LO - b_first;
    end else if (p < lo) begin
      s.base = tgt[1];
      diff   = p - gpsc_pkg::BRK_INNER_LO;
      span   = lo - gpsc_pkg::BRK_INNER_LO;
    end else if (p < hi) begin
      // flat centre
      s.base = tgt[2];
    end else if (p < gpsc_pkg::BRK_INNER_HI) begin
      s.base = tgt[3];
      diff   = p - hi;
      span   = gpsc_pkg::BRK_INNER_HI - hi;
    end else if (p < b_last) begin
      s.base = tgt[4];
      diff   = p - gpsc_pkg::BRK_INNER_HI;
      span   = b_last - gpsc_pkg::BRK_INNER_HI;
    end else begin
      s.base = tgt[5];
    end
    s.off = diff[gpsc_pkg::OFF_W-1:0];
    s.den = span[gpsc_pkg::OFF_W-1:0];
    return s;
  endfunction

  // one restoring division step for quotient bit sh
  function automatic gpsc_pkg::div_t div_step(input gpsc_pkg::div_t d, input int sh);
    gpsc_pkg::div_t r;
    logic [gpsc_pkg::NUM_W-1:0] dsh;
    r   = d;
    dsh = gpsc_pkg::NUM_W'(d.den) << sh;
    if (d.rem >= dsh) begin
      r.rem     = d.rem - dsh;
      r.quo[sh] = 1'b1;
    end
    return r;
  endfunction

  // numerator 40 * offset, then the first two quotient bits
  function automatic gpsc_pkg::div_t div_start(input gpsc_pkg::seg_t s);
    gpsc_pkg::div_t d;
    logic [gpsc_pkg::NUM_W-1:0] w;
    w      = gpsc_pkg::NUM_W'(s.off);
    d.base = s.base;
    d.neg  = s.neg;
    d.den  = s.den;
    d.rem  = (w << 5) + (w << 3);
    d.quo  = '0;
    d      = div_step(d, 5);
    d      = div_step(d, 4);
    return d;
  endfunction

  // rising slope rounds down, falling slope rounds the step up
  function automatic logic [7:0] div_finish(input gpsc_pkg::div_t d);
    logic [gpsc_pkg::OFF_W-1:0] q;
    q = d.quo;
    if (d.neg && (d.rem != '0)) begin
      q = q + 1'b1;
    end
    return d.neg ? (d.base - {2'b00, q}) : (d.base + {2'b00, q});
  endfunction

  logic [gpsc_pkg::DZ_W-1:0] dz;
  logic advance;

  // stage registers, lane 0 is X and lane 1 is Y
  logic valid_a, valid_b, valid_c, valid_d;
  gpsc_pkg::seg_t  seg_a [2];
  gpsc_pkg::div_t  div_b [2];
  gpsc_pkg::div_t  div_c [2];
  gpsc_pkg::div_t  div_d [2];
  gpsc_pkg::side_t side_a, side_b, side_c, side_d;
  gpsc_pkg::side_t side_next;

  // whole pipeline moves together, frozen only by a held result
  assign advance   = ~out_valid | out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  // dead zone register
  always_ff @(posedge clk) begin
    if (rst) begin
      dz <= gpsc_pkg::DZ_RESET;
    end else if (cfg_valid) begin
      dz <= dead_zone;
    end
  end

  // button remap and C axes
  always_comb begin
    side_next.button_word = '0;
    side_next.button_word[gpsc_pkg::BW_START] = start_byte[gpsc_pkg::SB_START];
    side_next.button_word[gpsc_pkg::BW_R]     = main_buttons[gpsc_pkg::MB_R];
    side_next.button_word[gpsc_pkg::BW_Z]     = main_buttons[gpsc_pkg::MB_Z];
    side_next.button_word[gpsc_pkg::BW_A]     = main_buttons[gpsc_pkg::MB_A];
    side_next.button_word[gpsc_pkg::BW_B]     = main_buttons[gpsc_pkg::MB_B];
    side_next.button_word[gpsc_pkg::BW_L]     = main_buttons[gpsc_pkg::MB_L];
    side_next.axis_cx = cstick_x;
    side_next.axis_cy = ~cstick_y;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      valid_d   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      valid_c   <= valid_b;
      valid_d   <= valid_c;
      out_valid <= valid_d;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      // segment select
      seg_a[0] <= classify(stick_x, dz, 1'b0);
      seg_a[1] <= classify(stick_y, dz, 1'b1);
      side_a   <= side_next;
      // quotient bits 5 and 4
      div_b[0] <= div_start(seg_a[0]);
      div_b[1] <= div_start(seg_a[1]);
      side_b   <= side_a;
      // quotient bits 3 and 2
      div_c[0] <= div_step(div_step(div_b[0], 3), 2);
      div_c[1] <= div_step(div_step(div_b[1], 3), 2);
      side_c   <= side_b;
      // quotient bits 1 and 0
      div_d[0] <= div_step(div_step(div_c[0], 1), 0);
      div_d[1] <= div_step(div_step(div_c[1], 1), 0);
      side_d   <= side_c;
      // output register
      axis_x      <= div_finish(div_d[0]);
      axis_y      <= div_finish(div_d[1]);
      button_word <= side_d.button_word;
      axis_cx     <= side_d.axis_cx;
      axis_cy     <= side_d.axis_cy;
    end
  end

endmodule

FILE: sim/tb_gamepad_report_stick_calibrator.sv
// self-checking testbench for the gamepad report stick calibrator
`timescale 1ns / 1ps

module tb_gamepad_report_stick_calibrator;

  // five register stages from input transfer to result
  localparam int LATENCY = 5;
  // cycles without any transfer before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 12;
  localparam int PHASE_REPORTS = 160;
  // phase in which the receiver blocks long enough to back the pipe up
  localparam int HOLD_PHASE = 3;
  localparam int LONG_HOLD = 150;

  typedef struct packed {
    logic [7:0] main_buttons;
    logic [7:0] start_byte;
    logic [7:0] stick_x;
    logic [7:0] stick_y;
    logic [7:0] cstick_x;
    logic [7:0] cstick_y;
  } report_t;

  typedef struct packed {
    logic [15:0] button_word;
    logic [7:0]  axis_x;
    logic [7:0]  axis_y;
    logic [7:0]  axis_cx;
    logic [7:0]  axis_cy;
  } mapped_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // every block input starts at a known value
  logic             in_valid = 1'b0;
  logic [7:0]       main_buttons = '0;
  logic [7:0]       start_byte = '0;
  logic [7:0]       stick_x = '0;
  logic [7:0]       stick_y = '0;
  logic [7:0]       cstick_x = '0;
  logic [7:0]       cstick_y = '0;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [gpsc_pkg::DZ_W-1:0] dead_zone = gpsc_pkg::DZ_RESET;

  logic        in_ready;
  logic        out_valid;
  logic        cfg_ready;
  logic [15:0] button_word;
  logic [7:0]  axis_x;
  logic [7:0]  axis_y;
  logic [7:0]  axis_cx;
  logic [7:0]  axis_cy;

  // reports waiting to be offered, results waiting to come back
  report_t         report_q [$];
  mapped_t         mapped_q [$];
  logic [gpsc_pkg::DZ_W-1:0] dz_write_q [$];

  // our copy of the dead zone register
  logic [gpsc_pkg::DZ_W-1:0] dz_shadow = gpsc_pkg::DZ_RESET;

  // idling controls, set per phase
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int rx_hold_req = 0;

  report_t tx_item;
  int      tx_gap = 0;
  int      gap_roll;
  mapped_t rx_want;
  int      rx_hold = 0;
  int      quiet_cycles = 0;
  int      fail_count = 0;

  // dead zone settings per phase, extremes and out-of-range values first
  logic [gpsc_pkg::DZ_W-1:0] dz_plan [8] = '{6'd1, 6'd56, 6'd0, 6'd63, 6'd57, 6'd31,
                                             6'd2, 6'd55};

  // directed stick positions on and beside every knee at the reset dead zone
  int x_edges [16] = '{0, 25, 26, 70, 71, 96, 97, 127, 128, 158, 159, 184, 185,
                       230, 231, 255};
  int y_edges [16] = '{255, 229, 228, 185, 184, 159, 158, 128, 127, 97, 96, 71,
                       70, 27, 26, 0};

  gamepad_report_stick_calibrator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .main_buttons (main_buttons),
    .start_byte   (start_byte),
    .stick_x      (stick_x),
    .stick_y      (stick_y),
    .cstick_x     (cstick_x),
    .cstick_y     (cstick_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_word  (button_word),
    .axis_x       (axis_x),
    .axis_y       (axis_y),
    .axis_cx      (axis_cx),
    .axis_cy      (axis_cy),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .dead_zone    (dead_zone)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // six-knee piecewise-linear stick map; the first knee above the
  // position picks the segment, so inverted segments are never reached
  function automatic logic [7:0] map_axis(input logic [7:0] raw, input bit is_y,
                                          input logic [gpsc_pkg::DZ_W-1:0] dz);
    int brk [6];
    int tgt [6];
    int pos;
    int seg;
    int num;
    int den;
    logic [7:0] mapped;
    pos = int'(raw);
    brk[0] = is_y ? int'(gpsc_pkg::Y_BRK_FIRST) : int'(gpsc_pkg::X_BRK_FIRST);
    brk[1] = int'(gpsc_pkg::BRK_INNER_LO);
    brk[2] = int'(gpsc_pkg::CENTRE) - int'(dz);
    brk[3] = int'(gpsc_pkg::CENTRE) + int'(dz);
    brk[4] = int'(gpsc_pkg::BRK_INNER_HI);
    brk[5] = is_y ? int'(gpsc_pkg::Y_BRK_LAST) : int'(gpsc_pkg::X_BRK_LAST);
    for (int k = 0; k < 6; k++)
      tgt[k] = is_y ? int'(gpsc_pkg::Y_TGT[k]) : int'(gpsc_pkg::X_TGT[k]);
    seg = 6;
    for (int k = 5; k >= 0; k--) if (pos < brk[k]) seg = k;
    if (seg == 0) begin
      mapped = 8'(tgt[0]);
    end else if (seg == 6) begin
      mapped = 8'(tgt[5]);
    end else begin
      // numerator is positive here, so truncation is the floor
      den = brk[seg] - brk[seg-1];
      num = tgt[seg-1] * den + (tgt[seg] - tgt[seg-1]) * (pos - brk[seg-1]);
      mapped = 8'(num / den);
    end
    return mapped;
  endfunction

  // expected result of one report under a given dead zone
  function automatic mapped_t map_report(input report_t r,
                                         input logic [gpsc_pkg::DZ_W-1:0] dz);
    mapped_t m;
    m = '0;
    m.button_word[gpsc_pkg::BW_START] = r.start_byte[gpsc_pkg::SB_START];
    m.button_word[gpsc_pkg::BW_R] = r.main_buttons[gpsc_pkg::MB_R];
    m.button_word[gpsc_pkg::BW_Z] = r.main_buttons[gpsc_pkg::MB_Z];
    m.button_word[gpsc_pkg::BW_A] = r.main_buttons[gpsc_pkg::MB_A];
    m.button_word[gpsc_pkg::BW_B] = r.main_buttons[gpsc_pkg::MB_B];
    m.button_word[gpsc_pkg::BW_L] = r.main_buttons[gpsc_pkg::MB_L];
    m.axis_x = map_axis(r.stick_x, 1'b0, dz);
    m.axis_y = map_axis(r.stick_y, 1'b1, dz);
    m.axis_cx = r.cstick_x;
    m.axis_cy = 8'd255 - r.cstick_y;
    return m;
  endfunction

  // stick position: often right on or beside a knee, otherwise anywhere
  function automatic logic [7:0] pick_stick(input bit is_y,
                                            input logic [gpsc_pkg::DZ_W-1:0] dz);
    int knee [6];
    int pos;
    knee[0] = is_y ? int'(gpsc_pkg::Y_BRK_FIRST) : int'(gpsc_pkg::X_BRK_FIRST);
    knee[1] = int'(gpsc_pkg::BRK_INNER_LO);
    knee[2] = int'(gpsc_pkg::CENTRE) - int'(dz);
    knee[3] = int'(gpsc_pkg::CENTRE) + int'(dz);
    knee[4] = int'(gpsc_pkg::BRK_INNER_HI);
    knee[5] = is_y ? int'(gpsc_pkg::Y_BRK_LAST) : int'(gpsc_pkg::X_BRK_LAST);
    if ($urandom_range(0, 9) < 4)
      pos = knee[$urandom_range(0, 5)] + int'($urandom_range(0, 2)) - 1;
    else
      pos = int'($urandom_range(0, 255));
    return 8'(pos);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // wait until nothing is queued, offered or outstanding, then let the pipe settle
  task automatic wait_drained;
    while (report_q.size() != 0 || in_valid || mapped_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  // report driver: predicts on every input transfer, then offers the next
  // report after a random gap; payload holds until the transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) mapped_q.push_back(map_report(tx_item, dz_shadow));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (report_q.size() > 0) begin
          tx_item = report_q.pop_front();
          main_buttons <= tx_item.main_buttons;
          start_byte <= tx_item.start_byte;
          stick_x <= tx_item.stick_x;
          stick_y <= tx_item.stick_y;
          cstick_x <= tx_item.cstick_x;
          cstick_y <= tx_item.cstick_y;
          in_valid <= 1'b1;
          // mostly back to back, sometimes short gaps, rarely long ones
          gap_roll = $urandom_range(0, 99);
          if (!tx_idle || gap_roll < 75) tx_gap = 0;
          else if (gap_roll < 96) tx_gap = $urandom_range(1, 3);
          else tx_gap = $urandom_range(10, 40);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each result transfer against the oldest
  // prediction, then decides whether to stall
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (mapped_q.size() == 0) begin
          $error("result transfer with no report outstanding");
          fail_count++;
        end else begin
          rx_want = mapped_q.pop_front();
          check_field("button_word", int'(rx_want.button_word), int'(button_word));
          check_field("axis_x", int'(rx_want.axis_x), int'(axis_x));
          check_field("axis_y", int'(rx_want.axis_y), int'(axis_y));
          check_field("axis_cx", int'(rx_want.axis_cx), int'(axis_cx));
          check_field("axis_cy", int'(rx_want.axis_cy), int'(axis_cy));
        end
      end
      // a long hold asked for by the stimulus, counted here
      if (rx_hold_req > 0) begin
        rx_hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (!rx_idle || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end
    end
  end

  // dead zone writes, only issued by the stimulus while the block is idle
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
      dz_shadow = gpsc_pkg::DZ_RESET;
    end else begin
      if (cfg_valid && cfg_ready) dz_shadow = dead_zone;
      if (!cfg_valid || cfg_ready) begin
        if (dz_write_q.size() > 0) begin
          dead_zone <= dz_write_q.pop_front();
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles in which no transfer of any kind happens
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // stimulus: directed reports at the reset dead zone, then random phases,
  // each under its own dead zone and idling pattern
  initial begin
    report_t item;
    logic [gpsc_pkg::DZ_W-1:0] dz_now;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // walking button bits, both start states, every knee and the position just below it
    for (int i = 0; i < 16; i++) begin
      item.main_buttons = (i < 8) ? (8'h01 << i) : ~(8'h01 << (i - 8));
      item.start_byte = i[0] ? 8'h02 : 8'hFD;
      item.stick_x = 8'(x_edges[i]);
      item.stick_y = 8'(y_edges[i]);
      item.cstick_x = 8'(i * 17);
      item.cstick_y = 8'(255 - i * 17);
      report_q.push_back(item);
    end
    // all bits clear, all bits set
    report_q.push_back('0);
    report_q.push_back('1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      dz_now = (p < 8) ? dz_plan[p] : gpsc_pkg::DZ_W'($urandom_range(0, 63));
      dz_write_q.push_back(dz_now);
      while (dz_write_q.size() != 0 || cfg_valid) @(negedge clk);

      // some phases run with no idling at all on one side or the other
      tx_idle = (p % 4 != 2) && (p != HOLD_PHASE);
      rx_idle = (p % 4 != 1);
      for (int n = 0; n < PHASE_REPORTS; n++) begin
        item.main_buttons = 8'($urandom_range(0, 255));
        item.start_byte = 8'($urandom_range(0, 255));
        item.stick_x = pick_stick(1'b0, dz_now);
        item.stick_y = pick_stick(1'b1, dz_now);
        item.cstick_x = 8'($urandom_range(0, 255));
        item.cstick_y = 8'($urandom_range(0, 255));
        report_q.push_back(item);
      end
      // receiver blocks while the sender keeps offering, so the pipe fills
      if (p == HOLD_PHASE) rx_hold_req = LONG_HOLD;
      // sender pauses here until every result is back
      wait_drained();
    end

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
